FILE: rtl/tcgw_pkg.sv
// ----------------------------------------------------------------------------
// tcgw_pkg: shared types and constants of the text console glyph writer
// Font geometry, request codes, register indexes and the command and result
// records passed between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package tcgw_pkg;

  // Font geometry
  localparam int unsigned FONT_W = 8;
  localparam int unsigned FONT_H = 16;
  localparam int unsigned ROW_W  = $clog2(FONT_H);

  // Command queue depth
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Request codes
  localparam logic [1:0] OP_CHAR   = 2'd0;
  localparam logic [1:0] OP_CURSOR = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Control characters
  localparam logic [7:0] CHR_LF = 8'd10;
  localparam logic [7:0] CHR_CR = 8'd13;

  // Result kinds
  localparam logic [1:0] KIND_GLYPH  = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CON_W     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CON_H     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET  = 3'd5;

  // Register reset values
  localparam logic [31:0] FG_COLOR_RST  = 32'hFFFF_FFFF;
  localparam logic [31:0] BG_COLOR_RST  = 32'h0000_0000;
  localparam logic [11:0] CON_W_RST     = 12'd640;
  localparam logic [11:0] CON_H_RST     = 12'd480;
  localparam logic [9:0]  X_OFFSET_RST  = 10'd48;
  localparam logic [9:0]  Y_OFFSET_RST  = 10'd32;

  // Back end sequencer states
  typedef enum logic {
    BK_GLYPH,
    BK_SCROLL
  } back_state_e;

  // Work queued for the back end
  typedef struct packed {
    logic        glyph;
    logic        scroll;
    logic        clear;
    logic [7:0]  chr;
    logic [11:0] x;
    logic [11:0] y;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [11:0] font_address;
    logic [31:0] set_color;
    logic [31:0] clear_color;
    logic        last;
  } res_t;

endpackage

FILE: rtl/text_console_glyph_writer.sv
// ----------------------------------------------------------------------------
// text_console_glyph_writer: text console renderer
// Turns character, set-cursor and clear requests into glyph row writes,
// scroll commands and clear commands for an external font ROM and blitter.
// ----------------------------------------------------------------------------
// A request is taken whenever the two-entry command queue has room; the front
// end updates the pixel cursor at once, so set-cursor and ignored requests
// produce nothing. The back end emits exactly one result per cycle when a
// command is queued and the output is not stalled: a printable character
// gives one glyph row write per font row, plus a scroll result when it also
// scrolls; a newline or carriage return that scrolls and a clear give a
// single result. The back end sequencer's single result per cycle sets the
// sustained rate. Commands pass through the queue and results through an
// output register. Configure registers only while no request is pending.
// ----------------------------------------------------------------------------
module text_console_glyph_writer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tcgw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         op_i,
  input  logic [7:0]                         chr_i,
  input  logic [8:0]                         cell_col_i,
  input  logic [7:0]                         cell_row_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         kind_o,
  output logic [11:0]                        pixel_x_o,
  output logic [11:0]                        pixel_y_o,
  output logic [11:0]                        font_address_o,
  output logic [31:0]                        set_color_o,
  output logic [31:0]                        clear_color_o,
  output logic                               last_o
);
  import tcgw_pkg::*;

  logic [31:0] fg_color_q, bg_color_q;
  logic [11:0] con_w_q, con_h_q;
  logic [9:0]  x_offset_q, y_offset_q;
  logic        q_full, push, pop, head_valid;
  cmd_t        push_cmd, head_cmd;
  res_t        res;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_color_q <= FG_COLOR_RST;
      bg_color_q <= BG_COLOR_RST;
      con_w_q    <= CON_W_RST;
      con_h_q    <= CON_H_RST;
      x_offset_q <= X_OFFSET_RST;
      y_offset_q <= Y_OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FG_COLOR: fg_color_q <= cfg_data_i;
        CFG_BG_COLOR: bg_color_q <= cfg_data_i;
        CFG_CON_W:    con_w_q    <= cfg_data_i[11:0];
        CFG_CON_H:    con_h_q    <= cfg_data_i[11:0];
        CFG_X_OFFSET: x_offset_q <= cfg_data_i[9:0];
        CFG_Y_OFFSET: y_offset_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  tcgw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .chr_i            (chr_i),
    .cell_col_i       (cell_col_i),
    .cell_row_i       (cell_row_i),
    .console_width_i  (con_w_q),
    .console_height_i (con_h_q),
    .x_offset_i       (x_offset_q),
    .y_offset_i       (y_offset_q),
    .q_full_i         (q_full),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  tcgw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  tcgw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .fg_color_i   (fg_color_q),
    .bg_color_i   (bg_color_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  // Drive the result fields
  assign kind_o         = res.kind;
  assign pixel_x_o      = res.pixel_x;
  assign pixel_y_o      = res.pixel_y;
  assign font_address_o = res.font_address;
  assign set_color_o    = res.set_color;
  assign clear_color_o  = res.clear_color;
  assign last_o         = res.last;

endmodule

FILE: rtl/tcgw_front.sv
// ----------------------------------------------------------------------------
// tcgw_front: request intake and cursor tracking
// Accepts one request a cycle while the queue has room, updates the pixel
// cursor, and pushes a command for every request that yields results.
// ----------------------------------------------------------------------------
module tcgw_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         chr_i,
  input  logic [8:0]         cell_col_i,
  input  logic [7:0]         cell_row_i,
  input  logic [11:0]        console_width_i,
  input  logic [11:0]        console_height_i,
  input  logic [9:0]         x_offset_i,
  input  logic [9:0]         y_offset_i,
  input  logic               q_full_i,
  output logic               push_o,
  output tcgw_pkg::cmd_t     cmd_o
);
  import tcgw_pkg::*;

  logic [11:0] cur_x_q, cur_x_d;
  logic [11:0] cur_y_q, cur_y_d;
  logic        accept;
  logic [11:0] xo, yo;
  logic [11:0] wmax, htrunc, hmax;
  logic [12:0] x_a, x_b;
  logic [13:0] y_a, y_b, y_c;
  logic        is_ctrl, wrap, scroll;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign xo         = 12'(x_offset_i);
  assign yo         = 12'(y_offset_i);

  // Right and bottom limits, clamped at zero
  assign wmax   = (console_width_i > xo) ? console_width_i - xo : '0;
  assign htrunc = console_height_i - 12'(console_height_i % 12'(FONT_H));
  assign hmax   = (htrunc > yo) ? htrunc - yo : '0;

  // Advance the cursor for a character
  assign is_ctrl = (chr_i == CHR_LF) || (chr_i == CHR_CR);
  always_comb begin
    case (chr_i)
      CHR_LF: begin
        x_a = 13'(xo);
        y_a = 14'(cur_y_q) + 14'(FONT_H);
      end
      CHR_CR: begin
        x_a = 13'(xo);
        y_a = 14'(cur_y_q);
      end
      default: begin
        x_a = 13'(cur_x_q) + 13'(FONT_W);
        y_a = 14'(cur_y_q);
      end
    endcase
  end

  // Wrap at the right limit, then back up at the bottom limit
  assign wrap   = x_a >= 13'(wmax);
  assign x_b    = wrap ? 13'(xo) : x_a;
  assign y_b    = wrap ? y_a + 14'(FONT_H) : y_a;
  assign scroll = y_b >= 14'(hmax);
  assign y_c    = scroll ? y_b - 14'(FONT_H) : y_b;

  // Next cursor per request
  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    case (op_i)
      OP_CHAR: begin
        cur_x_d = scroll ? xo : x_b[11:0];
        cur_y_d = y_c[11:0];
      end
      OP_CURSOR: begin
        cur_x_d = 12'(12'(cell_col_i) * 12'(FONT_W)) + xo;
        cur_y_d = 12'(12'(cell_row_i) * 12'(FONT_H)) + yo;
      end
      OP_CLEAR: begin
        cur_x_d = xo;
        cur_y_d = yo;
      end
      default: begin
        cur_x_d = cur_x_q;
        cur_y_d = cur_y_q;
      end
    endcase
  end

  // Build the command for the back end; glyph rows and scroll only for characters
  always_comb begin
    cmd_o.glyph  = (op_i == OP_CHAR) && !is_ctrl;
    cmd_o.scroll = (op_i == OP_CHAR) && scroll;
    cmd_o.clear  = (op_i == OP_CLEAR);
    cmd_o.chr    = chr_i;
    cmd_o.x      = cur_x_q;
    cmd_o.y      = cur_y_q;
    case (op_i)
      OP_CHAR:  push_o = accept && (!is_ctrl || scroll);
      OP_CLEAR: push_o = accept;
      default:  push_o = 1'b0;
    endcase
  end

  // Hold the cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= 12'(X_OFFSET_RST);
      cur_y_q <= 12'(Y_OFFSET_RST);
    end else if (accept) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
    end
  end

endmodule

FILE: rtl/tcgw_queue.sv
// ----------------------------------------------------------------------------
// tcgw_queue: command queue between front end and back end
// Small register FIFO; the head entry is visible to the back end directly.
// ----------------------------------------------------------------------------
module tcgw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcgw_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           head_valid_o,
  output tcgw_pkg::cmd_t head_cmd_o
);
  import tcgw_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o       = (count_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: rtl/tcgw_back.sv
// ----------------------------------------------------------------------------
// tcgw_back: result sequencer
// Expands the head command into glyph row writes, scroll and clear results,
// one a cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module tcgw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  tcgw_pkg::cmd_t head_cmd_i,
  output logic           pop_o,
  input  logic [31:0]    fg_color_i,
  input  logic [31:0]    bg_color_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcgw_pkg::res_t res_o
);
  import tcgw_pkg::*;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FONT_H - 1);

  back_state_e      state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;
  logic             emit;

  assign emit = head_valid_i && (!out_valid_q || out_ready_i);

  // Next state and row counter
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    if (emit) begin
      case (state_q)
        BK_GLYPH: begin
          if (head_cmd_i.glyph) begin
            if (row_q == LAST_ROW) begin
              row_d   = '0;
              state_d = head_cmd_i.scroll ? BK_SCROLL : BK_GLYPH;
            end else begin
              row_d = row_q + 1'b1;
            end
          end
        end
        BK_SCROLL: state_d = BK_GLYPH;
        default:   state_d = BK_GLYPH;
      endcase
    end
  end

  // Result for the current step
  always_comb begin
    res_d = '0;
    case (state_q)
      BK_GLYPH: begin
        if (head_cmd_i.clear) begin
          res_d.kind = KIND_CLEAR;
          res_d.last = 1'b1;
        end else if (head_cmd_i.glyph) begin
          res_d.kind         = KIND_GLYPH;
          res_d.pixel_x      = head_cmd_i.x;
          res_d.pixel_y      = head_cmd_i.y + 12'(row_q);
          res_d.font_address = 12'(12'(head_cmd_i.chr) * 12'(FONT_H)) + 12'(row_q);
          res_d.set_color    = fg_color_i;
          res_d.clear_color  = bg_color_i;
          res_d.last         = (row_q == LAST_ROW) && !head_cmd_i.scroll;
        end else begin
          res_d.kind = KIND_SCROLL;
          res_d.last = 1'b1;
        end
      end
      BK_SCROLL: begin
        res_d.kind = KIND_SCROLL;
        res_d.last = 1'b1;
      end
      default: res_d = '0;
    endcase
    pop_o       = emit && res_d.last;
    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_GLYPH;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
